@@ hdl/ppg_pkg.sv @@
package ppg_pkg;

   localparam int RAW_W  = 18;
   localparam int DATA_W = 24;
   localparam int HR_W   = 8;
   localparam int SPO2_W = 8;

   localparam int DIV_STEPS   = 24;
   localparam int HR_NUM      = 3000;
   localparam int PERIOD_LOW  = 14;
   localparam int PERIOD_HIGH = 100;
   localparam int SPO2_MAX    = 100;

   localparam logic [21:0] COEF_A = 22'd2953052;
   localparam logic [20:0] COEF_B = 21'd1989280;
   localparam logic [22:0] COEF_C = 23'd6215762;
   localparam logic [23:0] R_MAX  = 24'hFFFFFF;

   localparam logic [RAW_W-1:0] THRESH_RESET = 18'd100000;

   typedef struct packed {
      logic wr;
      logic rd;
      logic hr_load;
      logic div_step;
      logic ratio;
      logic r_load;
      logic sq;
      logic ar;
      logic fin;
   } ppg_cmd_type;

   typedef struct packed {
      logic contact;
      logic win_last;
   } ppg_sts_type;

endpackage

@@ hdl/ppg_ram.sv @@
module ppg_ram import ppg_pkg::*; #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 150
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/ppg_ctrl.sv @@
module ppg_ctrl import ppg_pkg::*; #(
   parameter int WINDOW_LEN = 150
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  ppg_sts_type                   sts,
   output ppg_cmd_type                   cmd,
   output logic [$clog2(WINDOW_LEN)-1:0] scan_addr
);

   localparam int AW = $clog2(WINDOW_LEN);
   localparam int CW = (AW > 5) ? AW : 5;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCAN, ST_SCAN_END, ST_HR_LOAD, ST_HR_DIV,
      ST_RATIO, ST_R_LOAD, ST_R_DIV, ST_SQ, ST_AR, ST_FIN
   } state_type;

   state_type     state_ff;
   logic [CW-1:0] cnt_ff;
   logic          rsp_valid_ff;
   logic          accept;
   logic          scan_done;
   logic          div_done;
   logic          rsp_set;

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign scan_addr  = cnt_ff[AW-1:0];
   assign scan_done  = (cnt_ff == CW'(WINDOW_LEN - 1));
   assign div_done   = (cnt_ff == CW'(DIV_STEPS - 1));
   assign rsp_set    = (accept && !sts.contact) || (state_ff == ST_FIN);

   always_comb begin
      cmd          = '0;
      cmd.wr       = accept && sts.contact;
      cmd.rd       = (state_ff == ST_SCAN);
      cmd.hr_load  = (state_ff == ST_HR_LOAD);
      cmd.div_step = (state_ff == ST_HR_DIV) || (state_ff == ST_R_DIV);
      cmd.ratio    = (state_ff == ST_RATIO);
      cmd.r_load   = (state_ff == ST_R_LOAD);
      cmd.sq       = (state_ff == ST_SQ);
      cmd.ar       = (state_ff == ST_AR);
      cmd.fin      = (state_ff == ST_FIN);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_set || (rsp_valid_ff && !rsp_tready);
         case (state_ff)
            ST_IDLE: begin
               cnt_ff <= '0;
               if (accept && sts.contact && sts.win_last) begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (scan_done) begin
                  state_ff <= ST_SCAN_END;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_SCAN_END: state_ff <= ST_HR_LOAD;
            ST_HR_LOAD: begin
               cnt_ff   <= '0;
               state_ff <= ST_HR_DIV;
            end
            ST_HR_DIV: begin
               if (div_done) begin
                  state_ff <= ST_RATIO;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_RATIO: state_ff <= ST_R_LOAD;
            ST_R_LOAD: begin
               cnt_ff   <= '0;
               state_ff <= ST_R_DIV;
            end
            ST_R_DIV: begin
               if (div_done) begin
                  state_ff <= ST_SQ;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_SQ: state_ff <= ST_AR;
            ST_AR: state_ff <= ST_FIN;
            ST_FIN: state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

@@ hdl/ppg_dp.sv @@
module ppg_dp import ppg_pkg::*; #(
   parameter int WINDOW_LEN = 150
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic [RAW_W-1:0]              csr_data,
   input  logic [RAW_W-1:0]              raw_ir,
   input  logic [RAW_W-1:0]              raw_red,
   input  logic [DATA_W-1:0]             filtered_ir,
   input  logic [DATA_W-1:0]             filtered_red,
   input  ppg_cmd_type                   cmd,
   input  logic [$clog2(WINDOW_LEN)-1:0] scan_addr,
   input  logic                          accept,
   output ppg_sts_type                   sts,
   output logic [HR_W-1:0]               heart_rate_bpm,
   output logic [SPO2_W-1:0]             spo2_percent,
   output logic                          no_contact,
   output logic                          ratio_fault
);

   localparam int AW = $clog2(WINDOW_LEN);
   localparam int SW = DATA_W + AW;
   localparam int PW = DATA_W + AW + 1;

   logic [RAW_W-1:0]  thresh_ff;
   logic [AW-1:0]     fill_ff;
   logic signed [SW-1:0] sum_ff, sum_in;
   logic signed [DATA_W-1:0] irmax_ff, irmin_ff, redmax_ff, redmin_ff;
   logic signed [DATA_W-1:0] fir, fred;
   logic first_wr;

   logic [DATA_W-1:0] ram_q;
   logic              rd_valid_ff;
   logic [AW-1:0]     rd_idx_ff;
   logic signed [PW-1:0] xs, nc, prod, sum_x;
   logic gt, lt, prev_gt_ff;
   logic have1_ff, have2_ff;
   logic [AW-1:0] first_ff, second_ff, period;
   logic per_ok;

   logic [47:0] rem_ff, div_ff;
   logic [23:0] quo_ff;
   logic [48:0] trial, trial_sub;
   logic        ge;

   logic [24:0] ir_diff, red_diff;
   logic [23:0] red_mag, ir_mag;
   logic [47:0] unum_ff, uden_ff;
   logic        neg_ff, sat_ff, fault_ff;
   logic [HR_W-1:0] hr_ff;

   logic [23:0] r;
   logic [47:0] r_sq;
   logic [44:0] br_full;
   logic [53:0] ar_full;
   logic [31:0] r2_ff;
   logic [28:0] br_ff;
   logic [37:0] ar_ff;
   logic signed [47:0] q;
   logic [SPO2_W-1:0] spo2;

   logic [HR_W-1:0]   hr_out_ff;
   logic [SPO2_W-1:0] spo2_out_ff;
   logic              nc_out_ff, fault_out_ff;

   assign fir  = filtered_ir;
   assign fred = filtered_red;
   assign sts.contact  = (raw_ir > thresh_ff) && (raw_red > thresh_ff);
   assign sts.win_last = (fill_ff == AW'(WINDOW_LEN - 1));
   assign first_wr     = (fill_ff == '0);
   assign sum_in = (first_wr ? SW'(0) : sum_ff) + SW'(fir);

   ppg_ram #(.WIDTH(DATA_W), .DEPTH(WINDOW_LEN)) u_ir_ram (
      .clock   (clock),
      .wr_en   (cmd.wr),
      .wr_addr (fill_ff),
      .wr_data (filtered_ir),
      .rd_en   (cmd.rd),
      .rd_addr (scan_addr),
      .rd_data (ram_q)
   );

   assign xs    = PW'($signed(ram_q));
   assign nc    = PW'(WINDOW_LEN);
   assign prod  = xs * nc;
   assign sum_x = PW'(sum_ff);
   assign gt    = prod > sum_x;
   assign lt    = prod < sum_x;
   assign period = second_ff - first_ff;
   assign per_ok = have2_ff && (int'(period) > PERIOD_LOW) && (int'(period) < PERIOD_HIGH);

   assign trial     = {rem_ff, quo_ff[23]};
   assign ge        = trial >= {1'b0, div_ff};
   assign trial_sub = trial - {1'b0, div_ff};

   assign ir_diff  = {irmax_ff[23], irmax_ff} - {irmin_ff[23], irmin_ff};
   assign red_diff = {redmax_ff[23], redmax_ff} - {redmin_ff[23], redmin_ff};
   assign red_mag  = redmin_ff[23] ? (~redmin_ff + 1'b1) : redmin_ff;
   assign ir_mag   = irmin_ff[23] ? (~irmin_ff + 1'b1) : irmin_ff;

   assign r       = neg_ff ? 24'd0 : (sat_ff ? R_MAX : quo_ff);
   assign r_sq    = r * r;
   assign br_full = COEF_B * r;
   assign ar_full = COEF_A * r2_ff;
   assign q = 48'(COEF_C) + 48'(br_ff) - 48'(ar_ff);

   always_comb begin
      if (fault_ff || q <= 0) begin
         spo2 = '0;
      end else if (q[47:16] > 32'(SPO2_MAX)) begin
         spo2 = SPO2_W'(SPO2_MAX);
      end else begin
         spo2 = q[23:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
         fill_ff   <= '0;
      end else begin
         if (csr_valid) begin
            thresh_ff <= csr_data;
         end
         if (accept) begin
            if (!sts.contact || sts.win_last) begin
               fill_ff <= '0;
            end else begin
               fill_ff <= fill_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         sum_ff    <= sum_in;
         irmax_ff  <= (first_wr || fir > irmax_ff) ? fir : irmax_ff;
         irmin_ff  <= (first_wr || fir < irmin_ff) ? fir : irmin_ff;
         redmax_ff <= (first_wr || fred > redmax_ff) ? fred : redmax_ff;
         redmin_ff <= (first_wr || fred < redmin_ff) ? fred : redmin_ff;
      end
      if (accept && !sts.contact) begin
         hr_out_ff    <= '1;
         spo2_out_ff  <= '1;
         nc_out_ff    <= 1'b1;
         fault_out_ff <= 1'b0;
      end else if (cmd.fin) begin
         hr_out_ff    <= hr_ff;
         spo2_out_ff  <= spo2;
         nc_out_ff    <= 1'b0;
         fault_out_ff <= fault_ff;
      end

      rd_valid_ff <= cmd.rd;
      rd_idx_ff   <= scan_addr;
      if (rd_valid_ff) begin
         prev_gt_ff <= gt;
         if (rd_idx_ff == '0) begin
            have1_ff <= 1'b0;
            have2_ff <= 1'b0;
         end else if (prev_gt_ff && lt) begin
            if (!have1_ff) begin
               have1_ff <= 1'b1;
               first_ff <= rd_idx_ff - 1'b1;
            end else if (!have2_ff) begin
               have2_ff  <= 1'b1;
               second_ff <= rd_idx_ff - 1'b1;
            end
         end
      end

      if (cmd.hr_load) begin
         rem_ff <= '0;
         quo_ff <= 24'(HR_NUM);
         div_ff <= 48'(period);
      end else if (cmd.r_load) begin
         rem_ff <= {8'd0, unum_ff[47:8]};
         quo_ff <= {unum_ff[7:0], 16'd0};
         div_ff <= uden_ff;
      end else if (cmd.div_step) begin
         rem_ff <= ge ? trial_sub[47:0] : trial[47:0];
         quo_ff <= {quo_ff[22:0], ge};
      end

      if (cmd.ratio) begin
         hr_ff   <= per_ok ? quo_ff[HR_W-1:0] : '0;
         unum_ff <= ir_diff[23:0] * red_mag;
         uden_ff <= red_diff[23:0] * ir_mag;
         neg_ff  <= redmin_ff[23] ^ irmin_ff[23];
      end
      if (cmd.r_load) begin
         fault_ff <= (uden_ff == '0);
         sat_ff   <= {8'd0, unum_ff} >= {uden_ff, 8'd0};
      end
      if (cmd.sq) begin
         r2_ff <= r_sq[47:16];
         br_ff <= br_full[44:16];
      end
      if (cmd.ar) begin
         ar_ff <= ar_full[53:16];
      end
   end

   assign heart_rate_bpm = hr_out_ff;
   assign spo2_percent   = spo2_out_ff;
   assign no_contact     = nc_out_ff;
   assign ratio_fault    = fault_out_ff;

endmodule

@@ hdl/pulse_rate_and_spo2_estimator.sv @@
// A no-contact item gives its result in the cycle after acceptance; an item that fills
// the window gives it after one mean-crossing scan of the IR RAM, two 24-step divides
// (HR, then R) and the square and SpO2 steps; other items none. One item per cycle is
// taken while filling unless a held result waits; the window-end pass holds input.
// Reset (synchronous, active high) empties the window, sets the threshold to 100000
// and drops any pending result; window RAM contents are not cleared.
module pulse_rate_and_spo2_estimator import ppg_pkg::*; #(
   parameter int WINDOW_LEN = 150
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // raw_ir, raw_red, filtered_ir, filtered_red, zero pad
   input  logic [87:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // heart_rate_bpm, spo2_percent
   output logic [15:0] rsp_tdata,
   // no_contact, ratio_fault
   output logic [1:0]  rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [17:0] csr_data
);

   ppg_cmd_type cmd;
   ppg_sts_type sts;
   logic [$clog2(WINDOW_LEN)-1:0] scan_addr;
   logic accept;

   assign csr_ready = 1'b1;
   assign accept    = req_tvalid && req_tready;

   ppg_ctrl #(.WINDOW_LEN(WINDOW_LEN)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd),
      .scan_addr  (scan_addr)
   );

   ppg_dp #(.WINDOW_LEN(WINDOW_LEN)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_data       (csr_data),
      .raw_ir         (req_tdata[17:0]),
      .raw_red        (req_tdata[35:18]),
      .filtered_ir    (req_tdata[59:36]),
      .filtered_red   (req_tdata[83:60]),
      .cmd            (cmd),
      .scan_addr      (scan_addr),
      .accept         (accept),
      .sts            (sts),
      .heart_rate_bpm (rsp_tdata[7:0]),
      .spo2_percent   (rsp_tdata[15:8]),
      .no_contact     (rsp_tuser[0]),
      .ratio_fault    (rsp_tuser[1])
   );

   assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (!rsp_tvalid || rsp_tready))
      else $error("input taken while a result is held");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == 16'hFFFF && !rsp_tuser[1]))
      else $error("no-contact result malformed");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata[15:8] <= 8'd100))
      else $error("spo2 out of range");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> (rsp_tdata[15:8] == 8'd0))
      else $error("ratio fault with nonzero spo2");

endmodule
